// ===== src/modulated_ir_proximity_detector_assert.svh =====
// Assertion macros for the proximity detector.
// Every macro samples on posedge clk and is disabled while rst_n is low.
`ifndef MODULATED_IR_PROXIMITY_DETECTOR_ASSERT_SVH
`define MODULATED_IR_PROXIMITY_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define MIPD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MIPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mipd_pkg.sv =====
// Shared types and constants for the proximity detector.
// No dependencies; used by every module in src.
package mipd_pkg;

  localparam int FIELD_W    = 12;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_W      = 16;
  localparam int QDEPTH     = 8;
  localparam int QPTR_W     = 3;
  localparam int QCNT_W     = 4;

  localparam logic [FIELD_W-1:0] THR_RESET = 12'd100;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic vld;
    logic restart;
  } pipe_ctl_t;

  // near sits in bit 0 so the packed struct matches out_tdata
  typedef struct packed {
    logic [FIELD_W-1:0] amb_avg;
    logic [FIELD_W-1:0] lit_avg;
    logic [FIELD_W-1:0] diff;
    logic               near;
  } result_t;

endpackage

// ===== src/mipd_lane.sv =====
// One averaging lane: ring store with valid bits, running sum, floor average.
// Depends on mipd_pkg.
module mipd_lane #(
  parameter int WINDOW_LENGTH = 8,
  parameter int SAMPLE_W      = 12,
  parameter int POS_W         = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mipd_pkg::pipe_ctl_t           ctl,
  input  logic                          clear_en,
  input  logic [POS_W-1:0]              pos,
  input  logic [SAMPLE_W-1:0]           sample,
  output logic [mipd_pkg::FIELD_W-1:0]  avg
);

  localparam int SUM_W   = $clog2(WINDOW_LENGTH * ((1 << SAMPLE_W) - 1) + 1);
  localparam int SH      = SUM_W + $clog2(WINDOW_LENGTH);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;

  logic [SAMPLE_W-1:0]      mem [WINDOW_LENGTH];
  logic [WINDOW_LENGTH-1:0] vld_r;
  logic [SAMPLE_W-1:0]      rd_r;
  logic [SAMPLE_W-1:0]      new_r;
  logic                     rdv_r;
  logic                     upd_r;
  logic                     clr_r;
  logic [SUM_W-1:0]         sum_r;
  logic [SUM_W-1:0]         sum_nxt;
  logic [SAMPLE_W-1:0]      avg_r;
  logic [SAMPLE_W-1:0]      old_val;
  logic [PROD_W-1:0]        prod;
  logic                     wr;
  logic                     clr;

  assign wr  = ctl.vld & (ctl.restart == mipd_pkg::OP_SAMPLE);
  assign clr = ctl.vld & (ctl.restart == mipd_pkg::OP_RESTART) & clear_en;

  // read-before-write: rd_r gets the entry being replaced
  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      rd_r  <= mem[pos];
      new_r <= sample;
    end
    if (wr) begin
      mem[pos] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rdv_r <= 1'b0;
      upd_r <= 1'b0;
      clr_r <= 1'b0;
      sum_r <= '0;
      avg_r <= '0;
    end else begin
      upd_r <= wr;
      clr_r <= clr;
      if (ctl.vld) begin
        rdv_r <= vld_r[pos];
      end
      if (clr) begin
        vld_r <= '0;
      end else if (wr) begin
        vld_r[pos] <= 1'b1;
      end
      sum_r <= sum_nxt;
      avg_r <= prod[SH +: SAMPLE_W];
    end
  end

  assign old_val = rdv_r ? rd_r : '0;

  always_comb begin
    priority if (clr_r) begin
      sum_nxt = '0;
    end else if (upd_r) begin
      sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(new_r);
    end else begin
      sum_nxt = sum_r;
    end
  end

  // floor divide by the window length through a reciprocal multiply
  assign prod = PROD_W'(sum_r) * PROD_W'(RECIP);
  assign avg  = mipd_pkg::FIELD_W'(avg_r);

endmodule

// ===== src/mipd_merge.sv =====
// Merge stage: absolute difference of the lane averages and near compare.
// Depends on mipd_pkg.
module mipd_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mipd_pkg::pipe_ctl_t           ctl,
  input  logic [mipd_pkg::FIELD_W-1:0]  lit_avg,
  input  logic [mipd_pkg::FIELD_W-1:0]  amb_avg,
  input  logic [mipd_pkg::FIELD_W-1:0]  thr,
  output logic                          push,
  output mipd_pkg::result_t             res
);

  logic [mipd_pkg::FIELD_W-1:0] last_diff_r;
  logic [mipd_pkg::FIELD_W-1:0] diff_new;
  logic [mipd_pkg::FIELD_W-1:0] diff_cur;
  logic                         is_sample;

  assign is_sample = (ctl.restart == mipd_pkg::OP_SAMPLE);
  assign diff_new  = (amb_avg > lit_avg) ? (amb_avg - lit_avg) : (lit_avg - amb_avg);
  // restart keeps the previous difference
  assign diff_cur  = is_sample ? diff_new : last_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_diff_r <= '0;
    end else if (ctl.vld && is_sample) begin
      last_diff_r <= diff_new;
    end
  end

  assign push        = ctl.vld;
  assign res.near    = (diff_cur > thr);
  assign res.diff    = diff_cur;
  assign res.lit_avg = lit_avg;
  assign res.amb_avg = amb_avg;

endmodule

// ===== src/mipd_outq.sv =====
// Result queue between the merge stage and the output channel.
// Depends on mipd_pkg.
module mipd_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mipd_pkg::result_t  din,
  input  logic               pop,
  output logic               not_empty,
  output mipd_pkg::result_t  dout
);

  mipd_pkg::result_t         q_r [mipd_pkg::QDEPTH];
  logic [mipd_pkg::QPTR_W:0] wp_r;
  logic [mipd_pkg::QPTR_W:0] rp_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r[mipd_pkg::QPTR_W-1:0]] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  assign not_empty = (wp_r != rp_r);
  assign dout      = q_r[rp_r[mipd_pkg::QPTR_W-1:0]];

endmodule

// ===== src/modulated_ir_proximity_detector.sv =====
// Top level of the modulated IR proximity detector: lit and ambient lanes,
// merge stage and result queue. Depends on mipd_pkg, mipd_lane, mipd_merge,
// mipd_outq and the assertion header.

// Takes one sample pair or restart per clock while in_tready is high and
// returns one result per item on out_tvalid, in order; throughput is one
// item per cycle, set by the running sum update in each lane (one store
// read and one store write per cycle). Up to eight items may be
// outstanding; in_tready drops while eight are outstanding. The stores
// reset through per-entry valid bits, so no clearing pass follows reset.
// Write the threshold only while idle.
module modulated_ir_proximity_detector #(
  parameter int WINDOW_LENGTH = 8,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [11:0] lit_mv, [23:12] ambient_mv
  input  logic [mipd_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] operation
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] near, [12:1] difference_mv, [24:13] lit_average_mv,
  // [36:25] ambient_average_mv, [39:37] zero
  output logic [mipd_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  // [11:0] near_threshold_mv
  input  logic [mipd_pkg::CFG_W-1:0]       cfg_data
);

  localparam int SAMPLE_W = (SAMPLE_BITS < mipd_pkg::FIELD_W) ? SAMPLE_BITS
                                                               : mipd_pkg::FIELD_W;
  localparam int POS_W    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LENGTH - 1);
  localparam logic [mipd_pkg::QCNT_W-1:0] CNT_MAX =
    mipd_pkg::QCNT_W'(mipd_pkg::QDEPTH);

  logic                          in_acc;
  logic                          out_acc;
  logic                          restart_acc;
  mipd_pkg::pipe_ctl_t           acc_ctl;
  mipd_pkg::pipe_ctl_t           d1_r;
  mipd_pkg::pipe_ctl_t           d2_r;
  mipd_pkg::pipe_ctl_t           d3_r;
  logic [POS_W-1:0]              pos_r;
  logic [POS_W-1:0]              pos_nxt;
  logic [mipd_pkg::QCNT_W-1:0]   cnt_r;
  logic [mipd_pkg::FIELD_W-1:0]  thr_r;
  logic [mipd_pkg::FIELD_W-1:0]  lit_avg;
  logic [mipd_pkg::FIELD_W-1:0]  amb_avg;
  logic                          push;
  mipd_pkg::result_t             mres;
  mipd_pkg::result_t             qout;
  logic [SAMPLE_W-1:0]           lit_s;
  logic [SAMPLE_W-1:0]           amb_s;

  assign in_tready   = (cnt_r < CNT_MAX);
  assign in_acc      = in_tvalid & in_tready;
  assign out_acc     = out_tvalid & out_tready;
  assign cfg_ready   = 1'b1;
  assign restart_acc = in_acc & (in_tuser == mipd_pkg::OP_RESTART);

  assign acc_ctl.vld     = in_acc;
  assign acc_ctl.restart = in_tuser;

  // drop reading bits above the sample width
  assign lit_s = in_tdata[SAMPLE_W-1:0];
  assign amb_s = in_tdata[mipd_pkg::FIELD_W +: SAMPLE_W];

  always_comb begin
    priority if (in_tuser == mipd_pkg::OP_RESTART) begin
      pos_nxt = '0;
    end else if (pos_r == POS_LAST) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
      thr_r <= mipd_pkg::THR_RESET;
      d1_r  <= '0;
      d2_r  <= '0;
      d3_r  <= '0;
    end else begin
      if (in_acc) begin
        pos_r <= pos_nxt;
      end
      cnt_r <= cnt_r + mipd_pkg::QCNT_W'(in_acc) - mipd_pkg::QCNT_W'(out_acc);
      if (cfg_valid) begin
        thr_r <= cfg_data[mipd_pkg::FIELD_W-1:0];
      end
      d1_r <= acc_ctl;
      d2_r <= d1_r;
      d3_r <= d2_r;
    end
  end

  mipd_lane #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SAMPLE_W      (SAMPLE_W),
    .POS_W         (POS_W)
  ) u_lit_lane (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (acc_ctl),
    .clear_en (1'b1),
    .pos      (pos_r),
    .sample   (lit_s),
    .avg      (lit_avg)
  );

  mipd_lane #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SAMPLE_W      (SAMPLE_W),
    .POS_W         (POS_W)
  ) u_amb_lane (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (acc_ctl),
    .clear_en (1'b0),
    .pos      (pos_r),
    .sample   (amb_s),
    .avg      (amb_avg)
  );

  mipd_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (d3_r),
    .lit_avg (lit_avg),
    .amb_avg (amb_avg),
    .thr     (thr_r),
    .push    (push),
    .res     (mres)
  );

  mipd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (mres),
    .pop       (out_acc),
    .not_empty (out_tvalid),
    .dout      (qout)
  );

  assign out_tdata = mipd_pkg::OUT_DATA_W'(qout);

`include "modulated_ir_proximity_detector_assert.svh"

  `MIPD_ASSERT_IMPLY(a_credit_bound, 1'b1, cnt_r <= CNT_MAX, "count above queue depth")
  `MIPD_ASSERT_IMPLY(a_out_has_credit, out_tvalid, cnt_r != '0, "result with none outstanding")
  `MIPD_ASSERT_NEXT(a_restart_rewinds, restart_acc, pos_r == '0, "restart kept position")
  `MIPD_ASSERT_NEXT(a_push_follows, d2_r.vld, push, "merge stage lost an item")

endmodule
